// ===== hw/rtl/wrp_pkg.sv =====
package wrp_pkg;

    localparam int WINDOW_SLOTS      = 16;
    localparam int BLOCK_OFFSET_BITS = 6;
    localparam int ADDR_W            = 64;
    localparam int BLOCK_W           = ADDR_W - BLOCK_OFFSET_BITS;
    localparam int SLOT_W            = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [BLOCK_W-1:0] t_block;

    localparam t_slot LAST_SLOT = t_slot'(WINDOW_SLOTS - 1);

    // one prefetch result
    typedef struct packed {
        logic [ADDR_W-1:0] prefetch_addr;
        logic              window_hit;
    } t_result;

    // next slot around the ring
    function automatic t_slot wrap_next(input t_slot s);
        t_slot r;
        if (s == LAST_SLOT) begin
            r = '0;
        end else begin
            r = s + t_slot'(1);
        end
        return r;
    endfunction

    // forward distance around the ring from b to a
    function automatic t_slot ring_dist(input t_slot a, input t_slot b);
        t_slot r;
        if (a >= b) begin
            r = a - b;
        end else begin
            r = t_slot'(int'(a) + WINDOW_SLOTS - int'(b));
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/wrp_window.sv =====
module wrp_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [wrp_pkg::ADDR_W-1:0]    i_addr,
    output wrp_pkg::t_result              o_result
);

    wrp_pkg::t_block                          r_ring [wrp_pkg::WINDOW_SLOTS];
    wrp_pkg::t_block                          n_ring [wrp_pkg::WINDOW_SLOTS];
    logic [wrp_pkg::WINDOW_SLOTS-1:0]         r_valid, n_valid;
    wrp_pkg::t_slot                           r_current, n_current;
    wrp_pkg::t_slot                           r_start, n_start;
    wrp_pkg::t_slot                           r_end, n_end;

    wrp_pkg::t_block                          w_blk;
    logic [wrp_pkg::WINDOW_SLOTS-1:0]         w_match;
    logic                                     w_hit;
    logic                                     w_at_end;
    wrp_pkg::t_slot                           w_found;
    wrp_pkg::t_slot                           w_new;
    wrp_pkg::t_slot                           w_cur_after;
    wrp_pkg::t_slot                           w_end_after;
    wrp_pkg::t_slot                           w_start_after;
    wrp_pkg::t_slot                           w_rd;
    wrp_pkg::t_slot                           w_trim_len;
    wrp_pkg::t_block                          w_next_blk;

    assign w_blk = i_addr[wrp_pkg::ADDR_W-1:wrp_pkg::BLOCK_OFFSET_BITS];

    // compare every valid slot, lowest matching slot wins
    always_comb begin
        w_found = '0;
        for (int i = 0; i < wrp_pkg::WINDOW_SLOTS; i++) begin
            w_match[i] = r_valid[i] && (r_ring[i] == w_blk);
        end
        for (int i = wrp_pkg::WINDOW_SLOTS - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_found = wrp_pkg::t_slot'(i);
            end
        end
    end

    assign w_hit      = |w_match;
    assign w_at_end   = (r_current == r_end);
    assign w_new      = wrp_pkg::wrap_next(r_current);
    assign w_trim_len = wrp_pkg::ring_dist(w_found, r_start);

    // next state of the window
    always_comb begin
        n_ring    = r_ring;
        n_valid   = r_valid;
        n_current = r_current;
        n_start   = r_start;
        n_end     = r_end;
        if (i_fire) begin
            if (w_hit) begin
                n_current = w_found;
                if (w_at_end) begin
                    // drop slots from start up to the hit slot
                    for (int i = 0; i < wrp_pkg::WINDOW_SLOTS; i++) begin
                        if (wrp_pkg::ring_dist(wrp_pkg::t_slot'(i), r_start) < w_trim_len) begin
                            n_valid[i] = 1'b0;
                        end
                    end
                    n_start = w_found;
                end
            end else begin
                n_current        = w_new;
                n_ring[w_new]    = w_blk;
                n_valid[w_new]   = 1'b1;
                n_end            = w_new;
            end
        end
    end

    // pick the slot to prefetch from the updated pointers
    assign w_cur_after   = w_hit ? w_found : w_new;
    assign w_end_after   = w_hit ? r_end : w_new;
    assign w_start_after = (w_hit && w_at_end) ? w_found : r_start;
    assign w_rd          = (w_cur_after == w_end_after) ? w_start_after
                                                        : wrp_pkg::wrap_next(w_cur_after);

    // forward the block being written on a miss
    assign w_next_blk = (!w_hit && (w_rd == w_new)) ? w_blk : r_ring[w_rd];

    assign o_result.prefetch_addr = {w_next_blk, {wrp_pkg::BLOCK_OFFSET_BITS{1'b0}}};
    assign o_result.window_hit    = w_hit;

    // hold window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < wrp_pkg::WINDOW_SLOTS; i++) begin
                r_ring[i] <= '0;
            end
            r_valid   <= '0;
            r_current <= wrp_pkg::LAST_SLOT;
            r_start   <= '0;
            r_end     <= '0;
        end else begin
            r_ring    <= n_ring;
            r_valid   <= n_valid;
            r_current <= n_current;
            r_start   <= n_start;
            r_end     <= n_end;
        end
    end

    // the slot current lands on always holds a live entry
    a_current_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> r_valid[r_current])
        else $error("current slot not valid after a transfer");

    // a miss leaves current at the end of the window
    a_miss_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !w_hit |=> (r_current == r_end))
        else $error("current slot not at window end after a miss");

endmodule

// ===== hw/rtl/wrp_out_reg.sv =====
module wrp_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  wrp_pkg::t_result  i_result,
    input  logic              i_m_tready,
    output logic              o_m_tvalid,
    output logic              o_s_tready,
    output wrp_pkg::t_result  o_result
);

    logic             r_valid, n_valid;
    wrp_pkg::t_result r_result;

    // take a new item when empty or when the held result leaves this cycle
    assign o_s_tready = !r_valid || i_m_tready;
    assign n_valid    = i_fire || (r_valid && !i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // load the result on each input transfer
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_result   = r_result;

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire |=> o_m_tvalid)
        else $error("input transfer produced no result");

endmodule

// ===== hw/rtl/window_replay_prefetcher.sv =====
// Window replay prefetcher: one prefetch result per demand access.
// The result is valid on the master side in the cycle after the input transfer.
// Throughput: 1 item per cycle; the parallel slot compare and window update
// finish in the accept cycle. A held result stalls the input only while the
// master side is not ready.
// Reset: synchronous active-low; clears the ring to zero, all valid bits,
// sets current slot to the last slot and start/end pointers to slot 0.
module window_replay_prefetcher (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [wrp_pkg::ADDR_W-1:0] i_s_tdata,   // [63:0] access_addr
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [wrp_pkg::ADDR_W-1:0] o_m_tdata,   // [63:0] prefetch_addr
    output logic                       o_m_tuser    // [0] window_hit
);

    logic             w_fire;
    wrp_pkg::t_result w_result;
    wrp_pkg::t_result w_out;

    assign w_fire = i_s_tvalid && o_s_tready;

    wrp_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_addr   (i_s_tdata),
        .o_result (w_result)
    );

    wrp_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_result   (w_result),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_s_tready (o_s_tready),
        .o_result   (w_out)
    );

    assign o_m_tdata = w_out.prefetch_addr;
    assign o_m_tuser = w_out.window_hit;

endmodule
